### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers for the block statistics unit
// assertions compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked only while out of reset
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/bmms_pkg.sv
// ----------------------------------------------------------------------------
// bmms_pkg: shared constants of the block statistics unit
// default widths and the fixed widths of the register and count ports
// ----------------------------------------------------------------------------
`default_nettype none

package bmms_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF  = 16;
  // block_length register and samples_used field are fixed at 16 bits
  localparam int CFG_BITS        = 16;
  localparam int USED_BITS       = 16;
  localparam int LEN_RESET       = 32;

endpackage

`default_nettype wire

### hw/rtl/bmms_if.sv
// ----------------------------------------------------------------------------
// bmms_if: valid/ready channels of the block statistics unit
// sample input, statistics result and block length configuration
// ----------------------------------------------------------------------------
`default_nettype none

interface bmms_in_if #(
  parameter int SAMPLE_BITS = bmms_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bmms_out_if #(
  parameter int SAMPLE_BITS = bmms_pkg::SAMPLE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [SAMPLE_BITS-1:0]         last_sample;
  logic [SAMPLE_BITS-1:0]         mean_value;
  logic [SAMPLE_BITS-1:0]         min_value;
  logic [SAMPLE_BITS-1:0]         max_value;
  logic [bmms_pkg::USED_BITS-1:0] samples_used;

  modport source (output valid, output last_sample, output mean_value, output min_value,
                  output max_value, output samples_used, input ready);
  modport sink   (input valid, input last_sample, input mean_value, input min_value,
                  input max_value, input samples_used, output ready);
endinterface

interface bmms_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bmms_pkg::CFG_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/bmms_accum.sv
// ----------------------------------------------------------------------------
// bmms_accum: running sum, count, minimum and maximum of the current block
// holds the block length register and flags the sample that closes a block
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bmms_accum #(
  parameter int SAMPLE_BITS = bmms_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = bmms_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [bmms_pkg::CFG_BITS-1:0]     cfg_data,
  input  wire logic                              acc_en,
  input  wire logic [SAMPLE_BITS-1:0]            sample,
  output logic                                   blk_done,
  output logic [SAMPLE_BITS+COUNT_BITS-1:0]      blk_sum,
  output logic [COUNT_BITS-1:0]                  blk_used,
  output logic [SAMPLE_BITS-1:0]                 blk_min,
  output logic [SAMPLE_BITS-1:0]                 blk_max
);

  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
  localparam int LEN_MAX  = (1 << COUNT_BITS) - 2;
  localparam int LEN_RST  = (bmms_pkg::LEN_RESET > LEN_MAX) ? LEN_MAX : bmms_pkg::LEN_RESET;

  logic [COUNT_BITS-1:0]  len_r, len_nxt;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt;

  // clamp the written length into 1..LEN_MAX
  always_comb begin
    if (cfg_data == '0) begin
      len_nxt = COUNT_BITS'(1);
    end else if (cfg_data > bmms_pkg::CFG_BITS'(LEN_MAX)) begin
      len_nxt = COUNT_BITS'(LEN_MAX);
    end else begin
      len_nxt = COUNT_BITS'(cfg_data);
    end
  end

  // first sample of a block loads both extremes
  always_comb begin
    sum_nxt = sum_r + SUM_BITS'(sample);
    cnt_nxt = cnt_r + 1'b1;
    if (cnt_r == '0) begin
      min_nxt = sample;
      max_nxt = sample;
    end else begin
      min_nxt = (sample < min_r) ? sample : min_r;
      max_nxt = (sample > max_r) ? sample : max_r;
    end
  end

  assign blk_done = acc_en && (cnt_nxt >= len_r);
  assign blk_sum  = sum_nxt;
  assign blk_used = cnt_nxt;
  assign blk_min  = min_nxt;
  assign blk_max  = max_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= COUNT_BITS'(LEN_RST);
      sum_r <= '0;
      cnt_r <= '0;
      min_r <= '0;
      max_r <= '0;
    end else begin
      if (cfg_we) begin
        len_r <= len_nxt;
      end
      if (blk_done) begin
        sum_r <= '0;
        cnt_r <= '0;
        min_r <= '0;
        max_r <= '0;
      end else if (acc_en) begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
        min_r <= min_nxt;
        max_r <= max_nxt;
      end
    end
  end

  `ASSERT_CLKD(a_len_range, clk, rst_n, (len_r != '0) && (len_r <= COUNT_BITS'(LEN_MAX)), "block length out of range")
  `ASSERT_CLKD(a_cnt_no_wrap, clk, rst_n, cnt_r != '1, "sample count reached its wrap value")
  `ASSERT_CLKD(a_clear_after_done, clk, rst_n, blk_done |=> (cnt_r == '0) && (sum_r == '0), "block state not cleared after closing beat")

endmodule

`default_nettype wire

### hw/rtl/bmms_div.sv
// ----------------------------------------------------------------------------
// bmms_div: restoring divider for the block mean
// one compare and subtract per cycle, one quotient bit per step
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bmms_div #(
  parameter int SAMPLE_BITS = bmms_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = bmms_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [SAMPLE_BITS+COUNT_BITS-1:0] dividend,
  input  wire logic [COUNT_BITS-1:0]             divisor,
  output logic                                   done,
  output logic [SAMPLE_BITS-1:0]                 quotient
);

  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
  localparam int STEP_W   = $clog2(SAMPLE_BITS);

  logic                   busy_r;
  logic                   done_r;
  logic [STEP_W-1:0]      step_r;
  logic [SUM_BITS-1:0]    rem_r;
  logic [SUM_BITS-1:0]    dsh_r;
  logic [COUNT_BITS-1:0]  dvs_r;
  logic [SAMPLE_BITS-1:0] quo_r;
  logic                   ge;
  logic [SUM_BITS-1:0]    diff;

  // quotient fits SAMPLE_BITS since the sum never exceeds used * max sample
  assign ge   = rem_r >= dsh_r;
  assign diff = rem_r - dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      dsh_r  <= SUM_BITS'({divisor, {(SAMPLE_BITS-1){1'b0}}});
      dvs_r  <= divisor;
      quo_r  <= '0;
      step_r <= STEP_W'(SAMPLE_BITS-1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= diff;
      end
      quo_r  <= {quo_r[SAMPLE_BITS-2:0], ge};
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r - 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `ASSERT_CLKD(a_start_idle, clk, rst_n, start |-> !busy_r, "divide started while busy")
  `ASSERT_CLKD(a_rem_below_dvs, clk, rst_n, done_r |-> (rem_r < SUM_BITS'(dvs_r)), "remainder not below divisor at end of divide")
  `ASSERT_CLKD(a_done_after_busy, clk, rst_n, done_r |-> $past(busy_r) && !busy_r, "done without a divide in flight")

endmodule

`default_nettype wire

### hw/rtl/block_min_max_mean_stats.sv
// ----------------------------------------------------------------------------
// block_min_max_mean_stats: per-block mean, minimum and maximum of ADC samples
// a sample that does not close a block is taken while ready stays high
// the closing beat drops ready; the divider works out the mean one quotient bit
// per cycle, the result is registered and ready returns once it moves to the
// output, and later still while an earlier result waits at the output
// synchronous active-low reset: block state cleared, block length 32
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module block_min_max_mean_stats #(
  parameter int SAMPLE_BITS = bmms_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = bmms_pkg::COUNT_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bmms_in_if.sink     in_ch,
  bmms_out_if.source  out_ch,
  bmms_cfg_if.sink    cfg_ch
);

  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   in_beat;
  logic                   out_free;
  logic                   blk_done;
  logic [SUM_BITS-1:0]    blk_sum;
  logic [COUNT_BITS-1:0]  blk_used;
  logic [SAMPLE_BITS-1:0] blk_min;
  logic [SAMPLE_BITS-1:0] blk_max;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] div_quo;

  logic [SAMPLE_BITS-1:0] last_r, min_r, max_r;
  logic [COUNT_BITS-1:0]  used_r;

  logic                           out_valid_r;
  logic [SAMPLE_BITS-1:0]         out_last_r, out_mean_r, out_min_r, out_max_r;
  logic [bmms_pkg::USED_BITS-1:0] out_used_r;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_beat      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  bmms_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_ch.valid),
    .cfg_data (cfg_ch.data),
    .acc_en   (in_beat),
    .sample   (in_ch.sample),
    .blk_done (blk_done),
    .blk_sum  (blk_sum),
    .blk_used (blk_used),
    .blk_min  (blk_min),
    .blk_max  (blk_max)
  );

  bmms_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (blk_done),
    .dividend (blk_sum),
    .divisor  (blk_used),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (blk_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_PUSH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // snapshot of the closed block while the mean is worked out
  always_ff @(posedge clk) begin
    if (blk_done) begin
      last_r <= in_ch.sample;
      min_r  <= blk_min;
      max_r  <= blk_max;
      used_r <= blk_used;
    end
    if ((state_r == ST_PUSH) && out_free) begin
      out_last_r <= last_r;
      out_mean_r <= div_quo;
      out_min_r  <= min_r;
      out_max_r  <= max_r;
      out_used_r <= bmms_pkg::USED_BITS'(used_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.last_sample  = out_last_r;
  assign out_ch.mean_value   = out_mean_r;
  assign out_ch.min_value    = out_min_r;
  assign out_ch.max_value    = out_max_r;
  assign out_ch.samples_used = out_used_r;

  `ASSERT_CLKD(a_done_in_div, clk, rst_n, div_done |-> (state_r == ST_DIV), "divider finished outside the divide state")
  `ASSERT_CLKD(a_close_to_div, clk, rst_n, blk_done |=> (state_r == ST_DIV), "closing beat did not start the divide")
  `ASSERT_CLKD(a_out_from_push, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_PUSH), "result shown without a finished block")

endmodule

`default_nettype wire

### sim/block_min_max_mean_stats_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_min_max_mean_stats_test: self-checking bench for the block stats unit
// a queue-fed driver offers samples, a clocked monitor checks every result
// beat against an in-bench model of the running sum, count, minimum and
// maximum, while the block length is changed between phases of idling
// ----------------------------------------------------------------------------

module block_min_max_mean_stats_test;

  localparam int SMP_W       = bmms_pkg::SAMPLE_BITS_DEF;
  localparam int CNT_W       = bmms_pkg::COUNT_BITS_DEF;
  localparam int SUM_W       = SMP_W + CNT_W;
  localparam int LEN_W       = bmms_pkg::CFG_BITS;
  localparam int USED_W      = bmms_pkg::USED_BITS;
  localparam int LEN_MAX     = (2 ** CNT_W) - 2;
  localparam int SMP_MAX     = (2 ** SMP_W) - 1;
  localparam int CLK_PERIOD  = 4;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [SMP_W-1:0]  last_sample;
    logic [SMP_W-1:0]  mean_value;
    logic [SMP_W-1:0]  min_value;
    logic [SMP_W-1:0]  max_value;
    logic [USED_W-1:0] samples_used;
  } block_stats_t;

  logic clk = 1'b0;
  logic rst_n;

  bmms_in_if  in_ch();
  bmms_out_if out_ch();
  bmms_cfg_if cfg_ch();

  block_min_max_mean_stats u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // samples waiting to be offered, block results still to arrive
  logic [SMP_W-1:0] sample_q[$];
  block_stats_t     stats_q[$];

  // model of the block state
  logic [LEN_W-1:0] blk_len;
  logic [SUM_W-1:0] acc_sum;
  logic [CNT_W-1:0] acc_count;
  logic [SMP_W-1:0] acc_min;
  logic [SMP_W-1:0] acc_max;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned hold_left;
  logic        hold_go;

  function automatic logic [LEN_W-1:0] clamp_length(input logic [LEN_W-1:0] value);
    if (value == '0) return LEN_W'(1);
    if (value > LEN_MAX) return LEN_W'(LEN_MAX);
    return value;
  endfunction

  function automatic void clear_block();
    acc_sum   = '0;
    acc_count = '0;
    acc_min   = '0;
    acc_max   = '0;
  endfunction

  // one accepted sample: update running stats, close the block when due
  function automatic void accumulate_sample(input logic [SMP_W-1:0] smp);
    block_stats_t     res;
    logic [SUM_W-1:0] quotient;
    if (acc_count == 0) begin
      acc_min = smp;
      acc_max = smp;
    end else begin
      if (smp < acc_min) acc_min = smp;
      if (smp > acc_max) acc_max = smp;
    end
    acc_sum   = acc_sum + smp;
    acc_count = acc_count + 1'b1;
    if (acc_count >= blk_len) begin
      quotient         = acc_sum / acc_count;
      res.last_sample  = smp;
      res.mean_value   = quotient[SMP_W-1:0];
      res.min_value    = acc_min;
      res.max_value    = acc_max;
      res.samples_used = acc_count;
      stats_q.push_back(res);
      clear_block();
    end
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return SMP_W'(SMP_MAX);
      default: return SMP_W'($urandom_range(SMP_MAX));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(11))
      0: return '0;
      1: return LEN_W'(1);
      2, 3: return LEN_W'(2 + $urandom_range(2));
      // long blocks stay open and get cut short by the next write
      4: return LEN_W'(LEN_MAX + $urandom_range(1));
      5: return LEN_W'($urandom_range(2000, 100));
      default: return LEN_W'($urandom_range(40, 1));
    endcase
  endfunction

  // driver: offers queued samples, holds valid until the beat is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) accumulate_sample(in_ch.sample);
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid  <= 1'b1;
          in_ch.sample <= sample_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each result beat against the oldest expectation
  always @(posedge clk) begin
    block_stats_t got;
    block_stats_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.last_sample, out_ch.mean_value, out_ch.min_value,
                out_ch.max_value, out_ch.samples_used};
        if (stats_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result beat: last %0d mean %0d min %0d max %0d used %0d",
                     got.last_sample, got.mean_value, got.min_value, got.max_value,
                     got.samples_used);
        end else begin
          want = stats_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $write("result mismatch: last %0d/%0d mean %0d/%0d min %0d/%0d ",
                     want.last_sample, got.last_sample, want.mean_value,
                     got.mean_value, want.min_value, got.min_value);
              $display("max %0d/%0d used %0d/%0d (expected/actual)",
                       want.max_value, got.max_value, want.samples_used,
                       got.samples_used);
            end
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && !hold_go &&
                      ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[block_min_max_mean_stats] ERROR");
      $finish;
    end
  end

  // sender pauses here until every queued sample is in and every result is out
  task automatic wait_quiet();
    while (sample_q.size() != 0 || in_ch.valid || stats_q.size() != 0) @(negedge clk);
    // a sample that closes no block may still be settling
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_block_length(input logic [LEN_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    blk_len = clamp_length(value);
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) sample_q.push_back(pick_sample());
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.sample   = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    hold_go        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_cnt   = 0;
    cycle_cnt      = 0;
    blk_len        = LEN_W'(bmms_pkg::LEN_RESET);
    clear_block();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // block at the reset length, opening with both sample extremes
    sample_q.push_back(SMP_W'(SMP_MAX));
    sample_q.push_back('0);
    queue_random(30);
    wait_quiet();

    // zero length saturates to one: every sample is a block
    write_block_length('0);
    sample_q.push_back('0);
    sample_q.push_back(SMP_W'(SMP_MAX));
    sample_q.push_back(SMP_W'(SMP_MAX / 2 + 1));
    wait_quiet();

    // pairs: equal extremes, rising and falling
    write_block_length(LEN_W'(2));
    sample_q.push_back(SMP_W'(SMP_MAX));
    sample_q.push_back(SMP_W'(SMP_MAX));
    sample_q.push_back('0);
    sample_q.push_back(SMP_W'(SMP_MAX));
    sample_q.push_back(SMP_W'(SMP_MAX));
    sample_q.push_back('0);
    wait_quiet();

    // length lowered while a block is part-filled: next sample closes it
    write_block_length(LEN_W'(5));
    sample_q.push_back(SMP_W'(100));
    sample_q.push_back(SMP_W'(200));
    sample_q.push_back(SMP_W'(50));
    wait_quiet();
    write_block_length(LEN_W'(2));
    sample_q.push_back(SMP_W'(7));
    wait_quiet();

    // all-ones write saturates to the longest block, left open for the next write
    write_block_length('1);
    queue_random(16);
    wait_quiet();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (ph == 0) begin
        // receiver holds off while samples keep coming, so the input backs up
        write_block_length(LEN_W'(1));
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        queue_random(24);
        wait_quiet();
      end
      for (int k = 0; k < 4; k++) begin
        wait_quiet();
        write_block_length(pick_length());
        queue_random($urandom_range(40, 20));
      end
    end

    wait_quiet();
    if (mismatch_cnt == 0) begin
      $display("[block_min_max_mean_stats] OK");
    end else begin
      $display("[block_min_max_mean_stats] ERROR");
    end
    $finish;
  end

endmodule
